// ----- rtl/core/ofgs_pkg.sv -----
// ofgs_pkg: shared constants, register codes and structs for the ground speed block
// no dependencies; used by every file in rtl/core except ofgs_if
package ofgs_pkg;

	localparam int MAX_POINTS = 128;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DIV_W      = 49;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam int DEPTH_W    = 36;

	localparam logic [15:0] ERR_LIMIT = 16'd2560;
	localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_LEFT_INTERCEPT  = 3'd0,
		REG_LEFT_SLOPE      = 3'd1,
		REG_RIGHT_INTERCEPT = 3'd2,
		REG_RIGHT_SLOPE     = 3'd3,
		REG_VELOCITY_SCALE  = 3'd4,
		REG_IMAGE_ROWS      = 3'd5,
		REG_IMAGE_COLS      = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic signed [16:0] left_intercept;
		logic signed [15:0] left_slope;
		logic signed [16:0] right_intercept;
		logic signed [15:0] right_slope;
		logic [31:0]        velocity_scale;
		logic [11:0]        image_rows;
		logic [11:0]        image_cols;
	} cfg_t;

	// classified feature handed from front to back
	typedef struct packed {
		logic                      kept;
		logic                      wall;
		logic                      last;
		logic signed [DEPTH_W-1:0] d1;
		logic signed [DEPTH_W-1:0] d2;
	} q_item_t;

endpackage

// ----- rtl/core/ofgs_if.sv -----
// ofgs channel interfaces: feature input, result output, register write
// no dependencies
interface ofgs_feature_if;
	logic        valid;
	logic        ready;
	logic [15:0] prev_x;
	logic [15:0] prev_y;
	logic [15:0] next_x;
	logic [15:0] next_y;
	logic        found;
	logic [15:0] track_error;
	logic        last_feature;
	modport source(output valid, prev_x, prev_y, next_x, next_y, found, track_error,
		last_feature, input ready);
	modport sink(input valid, prev_x, prev_y, next_x, next_y, found, track_error,
		last_feature, output ready);
endinterface

interface ofgs_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_speed;
	logic               speed_valid;
	logic               on_wall;
	logic               divide_fault;
	logic signed [31:0] average_speed;
	logic               average_valid;
	logic [7:0]         valid_count;
	modport source(output valid, point_speed, speed_valid, on_wall, divide_fault,
		average_speed, average_valid, valid_count, input ready);
	modport sink(input valid, point_speed, speed_valid, on_wall, divide_fault,
		average_speed, average_valid, valid_count, output ready);
endinterface

interface ofgs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/optical_flow_ground_speed.sv -----
// optical_flow_ground_speed: top level, register file plus front, queue and back
// depends on ofgs_pkg, ofgs_if, ofgs_front, ofgs_fifo, ofgs_back
//
// channel    dir  payload
// feature    in   prev_x, prev_y, next_x, next_y, found, track_error, last_feature
// result     out  point_speed, speed_valid, on_wall, divide_fault, average_speed,
//                 average_valid, valid_count
// cfg_wr     in   index, data (register write, always ready)
//
// the front takes a feature every cycle while the two-entry queue has room
// the back takes one feature at a time: a rejected or zero-depth feature goes straight
// to the frame sum, a kept one runs two 49-bit dividers side by side, then magnitude, multiply and saturate
// the last feature of a frame with kept points adds the average division
// reset clears control state and loads the register reset values
// a stalled result holds in the output register while the front keeps filling
module optical_flow_ground_speed (
	input logic           clk,
	input logic           arst_n,
	ofgs_feature_if.sink  feature,
	ofgs_result_if.source result,
	ofgs_cfg_if.sink      cfg_wr
);
	ofgs_pkg::cfg_t    cfg_q;
	logic              push_valid;
	logic              push_ready;
	ofgs_pkg::q_item_t push_data;
	logic              pop_valid;
	logic              pop_ready;
	ofgs_pkg::q_item_t pop_data;

	assign cfg_wr.ready = 1'b1;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_intercept  <= '0;
			cfg_q.left_slope      <= '0;
			cfg_q.right_intercept <= '0;
			cfg_q.right_slope     <= '0;
			cfg_q.velocity_scale  <= 32'd65536;
			cfg_q.image_rows      <= 12'd480;
			cfg_q.image_cols      <= 12'd640;
		end else if (cfg_wr.valid && cfg_wr.ready) begin
			case (cfg_wr.index)
				ofgs_pkg::REG_LEFT_INTERCEPT:  cfg_q.left_intercept  <= cfg_wr.data[16:0];
				ofgs_pkg::REG_LEFT_SLOPE:      cfg_q.left_slope      <= cfg_wr.data[15:0];
				ofgs_pkg::REG_RIGHT_INTERCEPT: cfg_q.right_intercept <= cfg_wr.data[16:0];
				ofgs_pkg::REG_RIGHT_SLOPE:     cfg_q.right_slope     <= cfg_wr.data[15:0];
				ofgs_pkg::REG_VELOCITY_SCALE:  cfg_q.velocity_scale  <= cfg_wr.data;
				ofgs_pkg::REG_IMAGE_ROWS:      cfg_q.image_rows      <= cfg_wr.data[11:0];
				ofgs_pkg::REG_IMAGE_COLS:      cfg_q.image_cols      <= cfg_wr.data[11:0];
				default: ;
			endcase
		end
	end

	// filter, side pick and line test
	ofgs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feature    (feature),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples the registered front from the iterative back
	ofgs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// reciprocals, speed, frame sum and average, result transaction
	ofgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg       (cfg_q),
		.result    (result)
	);
endmodule

// ----- rtl/core/ofgs_div.sv -----
// ofgs_div: unsigned restoring divider, one quotient bit per cycle
// depends on ofgs_pkg
module ofgs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ofgs_pkg::DIV_W-1:0] dividend,
	input  logic [ofgs_pkg::DIV_W-1:0] divisor,
	output logic                       busy,
	output logic [ofgs_pkg::DIV_W-1:0] quotient
);
	logic [ofgs_pkg::DIV_W:0]       rem_q;
	logic [ofgs_pkg::DIV_W-1:0]     quo_q;
	logic [ofgs_pkg::DIV_W-1:0]     dvs_q;
	logic [ofgs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [ofgs_pkg::DIV_W:0]       trial;
	logic                           fits;

	assign trial = {rem_q[ofgs_pkg::DIV_W-1:0], quo_q[ofgs_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ofgs_pkg::DIV_CNT_W'(ofgs_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != ofgs_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[ofgs_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/core/ofgs_fifo.sv -----
// ofgs_fifo: two-entry queue of classified features between front and back
// depends on ofgs_pkg
module ofgs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  ofgs_pkg::q_item_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output ofgs_pkg::q_item_t pop_data
);
	ofgs_pkg::q_item_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end
endmodule

// ----- rtl/core/ofgs_front.sv -----
// ofgs_front: accepts features, filters them, picks side, runs the wall line test
// depends on ofgs_pkg and ofgs_if
module ofgs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ofgs_feature_if.sink           feature,
	input  ofgs_pkg::cfg_t         cfg,
	output logic                   push_valid,
	input  logic                   push_ready,
	output ofgs_pkg::q_item_t      push_data
);
	logic [11:0]        px;
	logic [10:0]        cx;
	logic               left;
	logic signed [16:0] ic_sel;
	logic signed [15:0] sl_sel;
	logic               accept;

	logic               v_s1;
	logic               kept_s1;
	logic               last_s1;
	logic signed [16:0] ic_s1;
	logic [10:0]        cy_s1;
	logic [15:0]        prev_y_s1;
	logic [15:0]        next_y_s1;
	logic signed [28:0] pcols_s1;
	logic signed [28:0] ppx_s1;
	logic signed [28:0] pd1_s1;
	logic signed [32:0] pd2_s1;

	logic signed [35:0] t;
	logic signed [19:0] a0;
	logic signed [35:0] thr;
	logic signed [35:0] ic12;
	logic signed [35:0] d1w;
	logic signed [35:0] d2w;
	logic               wall;

	assign px     = feature.prev_x[15:4];
	assign cx     = cfg.image_cols[11:1];
	assign left   = px < {1'b0, cx};
	assign ic_sel = left ? cfg.left_intercept : cfg.right_intercept;
	assign sl_sel = left ? cfg.left_slope : cfg.right_slope;

	assign feature.ready = !v_s1 || push_ready;
	assign accept        = feature.valid && feature.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// slope products, one multiplier each
	always_ff @(posedge clk) begin
		if (accept) begin
			kept_s1   <= feature.found && (feature.track_error < ofgs_pkg::ERR_LIMIT);
			last_s1   <= feature.last_feature;
			ic_s1     <= ic_sel;
			cy_s1     <= cfg.image_rows[11:1];
			prev_y_s1 <= feature.prev_y;
			next_y_s1 <= feature.next_y;
			pcols_s1  <= sl_sel * $signed({1'b0, cfg.image_cols});
			ppx_s1    <= sl_sel * $signed({1'b0, px});
			pd1_s1    <= sl_sel * ($signed({1'b0, px}) - $signed({2'b0, cx}));
			pd2_s1    <= sl_sel * ($signed({1'b0, feature.next_x}) - $signed({2'b0, cx, 4'b0}));
		end
	end

	always_comb begin
		ic12 = $signed({{7{ic_s1[16]}}, ic_s1, 12'b0});
		t    = ic12 + $signed({9'b0, cy_s1, 16'b0})
			- $signed({{4{pcols_s1[28]}}, pcols_s1, 3'b0});
		// edge offset in whole pixels, rounded toward zero
		a0   = $signed(t[35:16]) + $signed({19'b0, t[35] && (t[15:0] != 16'd0)});
		thr  = $signed({{7{ppx_s1[28]}}, ppx_s1}) + $signed({{4{a0[19]}}, a0, 12'b0});
		wall = $signed({12'b0, prev_y_s1, 8'b0}) < thr;
		d1w  = ic12 + $signed({{3{pd1_s1[28]}}, pd1_s1, 4'b0});
		d2w  = ic12 + $signed({{3{pd2_s1[32]}}, pd2_s1});
	end

	assign push_valid     = v_s1;
	assign push_data.kept = kept_s1;
	assign push_data.wall = kept_s1 && wall;
	assign push_data.last = last_s1;
	assign push_data.d1   = wall ? d1w : $signed({20'b0, prev_y_s1});
	assign push_data.d2   = wall ? d2w : $signed({20'b0, next_y_s1});
endmodule

// ----- rtl/core/ofgs_back.sv -----
// ofgs_back: reciprocals, scaled speed, frame sum and average, result register
// depends on ofgs_pkg, ofgs_if and ofgs_div
module ofgs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  ofgs_pkg::q_item_t pop_data,
	input  ofgs_pkg::cfg_t    cfg,
	ofgs_result_if.source     result
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_MAG, ST_MUL, ST_SAT, ST_ACC, ST_CHK, ST_AVG, ST_OUT
	} state_t;

	state_t                          state_q;
	ofgs_pkg::q_item_t               item_q;
	logic signed [50:0]              diff_q;
	logic                            neg_q;
	logic [49:0]                     mag_q;
	logic [49:0]                     p_hi_q;
	logic [63:0]                     p_lo_q;
	logic signed [31:0]              speed_q;
	logic                            fault_q;
	logic signed [47:0]              sum_q;
	logic [ofgs_pkg::CNT_W-1:0]      cnt_q;
	logic signed [31:0]              avg_q;
	logic                            avg_ok_q;

	logic                            out_v_q;
	logic signed [31:0]              o_speed_q;
	logic                            o_valid_q;
	logic                            o_wall_q;
	logic                            o_fault_q;
	logic signed [31:0]              o_avg_q;
	logic                            o_avg_ok_q;
	logic [7:0]                      o_cnt_q;

	logic                            take;
	logic                            load_out;
	logic                            zero1;
	logic                            zero2;
	logic                            recip_go;
	logic                            avg_go;
	logic [ofgs_pkg::DIV_W-1:0]      num;
	logic [ofgs_pkg::DEPTH_W-1:0]    mag1;
	logic [ofgs_pkg::DEPTH_W-1:0]    mag2;
	logic [47:0]                     sum_mag;
	logic                            start0;
	logic [ofgs_pkg::DIV_W-1:0]      dvd0;
	logic [ofgs_pkg::DIV_W-1:0]      dvs0;
	logic                            busy0;
	logic                            busy1;
	logic [ofgs_pkg::DIV_W-1:0]      q0;
	logic [ofgs_pkg::DIV_W-1:0]      q1;
	logic signed [49:0]              r1;
	logic signed [49:0]              r2;
	logic [50:0]                     r_prod;

	assign pop_ready = state_q == ST_IDLE;
	assign take      = pop_valid && pop_ready;
	assign load_out  = (state_q == ST_OUT) && (!out_v_q || result.ready);
	assign zero1     = pop_data.d1 == '0;
	assign zero2     = pop_data.d2 == '0;
	assign recip_go  = take && pop_data.kept && !zero1 && !zero2;
	assign avg_go    = (state_q == ST_CHK) && item_q.last && (cnt_q != '0);

	assign num  = pop_data.wall ? ofgs_pkg::DIV_W'(49'h1 << 48) : ofgs_pkg::DIV_W'(49'h1 << 36);
	assign mag1 = pop_data.d1[35] ? ofgs_pkg::DEPTH_W'(-pop_data.d1) : pop_data.d1;
	assign mag2 = pop_data.d2[35] ? ofgs_pkg::DEPTH_W'(-pop_data.d2) : pop_data.d2;
	assign sum_mag = sum_q[47] ? 48'(-sum_q) : sum_q;

	// divider 0 is shared between the first reciprocal and the frame average
	assign start0 = recip_go || avg_go;
	assign dvd0   = avg_go ? ofgs_pkg::DIV_W'(sum_mag) : num;
	assign dvs0   = avg_go ? ofgs_pkg::DIV_W'(cnt_q) : ofgs_pkg::DIV_W'(mag1);

	ofgs_div u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start0),
		.dividend (dvd0),
		.divisor  (dvs0),
		.busy     (busy0),
		.quotient (q0)
	);

	ofgs_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (recip_go),
		.dividend (num),
		.divisor  (ofgs_pkg::DIV_W'(mag2)),
		.busy     (busy1),
		.quotient (q1)
	);

	assign r1 = item_q.d1[35] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
	assign r2 = item_q.d2[35] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
	assign r_prod = {1'b0, p_hi_q} + {19'b0, p_lo_q[63:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) out_v_q <= 1'b1;
			else if (result.valid && result.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						item_q <= pop_data;
						if (!pop_data.kept) begin
							fault_q <= 1'b0;
							speed_q <= '0;
							state_q <= ST_ACC;
						end else if (zero1 || zero2) begin
							fault_q <= 1'b1;
							if (cfg.velocity_scale == '0 || (zero1 && zero2)) speed_q <= '0;
							else if (zero1) speed_q <= ofgs_pkg::SAT_POS;
							else speed_q <= ofgs_pkg::SAT_NEG;
							state_q <= ST_ACC;
						end else begin
							fault_q <= 1'b0;
							speed_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (!busy0 && !busy1) begin
						diff_q  <= $signed({r1[49], r1}) - $signed({r2[49], r2});
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					neg_q   <= diff_q[50];
					mag_q   <= diff_q[50] ? 50'(-diff_q) : 50'(diff_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					p_hi_q  <= cfg.velocity_scale * mag_q[49:32];
					p_lo_q  <= cfg.velocity_scale * mag_q[31:0];
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (neg_q) begin
						speed_q <= (r_prod >= 51'h8000_0000) ? ofgs_pkg::SAT_NEG
							: -$signed(r_prod[31:0]);
					end else begin
						speed_q <= (r_prod > 51'h7FFF_FFFF) ? ofgs_pkg::SAT_POS
							: $signed(r_prod[31:0]);
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (item_q.kept && cnt_q < ofgs_pkg::CNT_W'(ofgs_pkg::MAX_POINTS)) begin
						sum_q <= sum_q + 48'(speed_q);
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					avg_q    <= '0;
					avg_ok_q <= 1'b0;
					state_q  <= avg_go ? ST_AVG : ST_OUT;
				end
				ST_AVG: begin
					if (!busy0) begin
						avg_q    <= sum_q[47] ? -$signed(q0[31:0]) : $signed(q0[31:0]);
						avg_ok_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						o_speed_q  <= speed_q;
						o_valid_q  <= item_q.kept;
						o_wall_q   <= item_q.wall;
						o_fault_q  <= fault_q;
						o_avg_q    <= avg_q;
						o_avg_ok_q <= avg_ok_q;
						o_cnt_q    <= 8'(cnt_q);
						if (item_q.last) begin
							sum_q <= '0;
							cnt_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid         = out_v_q;
	assign result.point_speed   = o_speed_q;
	assign result.speed_valid   = o_valid_q;
	assign result.on_wall       = o_wall_q;
	assign result.divide_fault  = o_fault_q;
	assign result.average_speed = o_avg_q;
	assign result.average_valid = o_avg_ok_q;
	assign result.valid_count   = o_cnt_q;
endmodule
